// ----- rtl/tlss_pkg.sv -----
// Shared types and constants for the tag level stack with search unit.
// No dependencies; imported by every module of the block.
package tlss_pkg;

   localparam int DEPTH         = 16;
   localparam int CountWidth    = $clog2(DEPTH + 1);
   localparam int TagWidth      = 8;
   localparam int LevelWidth    = 8;
   localparam int OpWidth       = 3;
   localparam int RspCountWidth = 5;

   typedef enum logic [OpWidth-1:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_SHIFT    = 3'd2,
      OP_TOP      = 3'd3,
      OP_CONTAINS = 3'd4,
      OP_FIND     = 3'd5
   } opcode_type;

   // Command broadcast to every cell; push, pop and shift are already
   // qualified with the accept handshake.
   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic                  shift;
      opcode_type            opcode;
      logic [TagWidth-1:0]   tag;
      logic [LevelWidth-1:0] level;
   } cmd_type;

   // What one cell offers to the result collector.
   typedef struct packed {
      logic                  pick;
      logic                  full_match;
      logic [TagWidth-1:0]   tag;
      logic [LevelWidth-1:0] level;
   } cell_resp_type;

endpackage

// ----- rtl/tlss_cell.sv -----
// One storage cell of the entry row: holds a (tag, level) pair and a valid bit.
// Depends on tlss_pkg.
module tlss_cell import tlss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  valid_below,
   input  logic                  valid_above,
   input  logic [TagWidth-1:0]   tag_above,
   input  logic [LevelWidth-1:0] level_above,
   input  logic                  hit_below,
   output logic                  hit_out,
   output logic                  valid_out,
   output logic [TagWidth-1:0]   tag_out,
   output logic [LevelWidth-1:0] level_out,
   output cell_resp_type         resp
);

   logic                  valid_ff, valid_in;
   logic [TagWidth-1:0]   tag_ff, tag_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic                  tag_hit;
   logic                  top_sel;
   logic                  find_sel;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      level_in = level_ff;
      // fill the first free slot
      if (cmd.push && !valid_ff && valid_below) begin
         valid_in = 1'b1;
         tag_in   = cmd.tag;
         level_in = cmd.level;
      end
      // drop the top entry
      if (cmd.pop && valid_ff && !valid_above) begin
         valid_in = 1'b0;
      end
      // advance everything one cell toward the bottom
      if (cmd.shift) begin
         valid_in = valid_above;
         tag_in   = tag_above;
         level_in = level_above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      level_ff <= level_in;
   end

   assign tag_hit  = valid_ff && (tag_ff == cmd.tag);
   assign top_sel  = valid_ff && !valid_above;
   assign find_sel = tag_hit && !hit_below;
   assign hit_out  = hit_below || tag_hit;

   assign valid_out = valid_ff;
   assign tag_out   = tag_ff;
   assign level_out = level_ff;

   always_comb begin
      resp.full_match = tag_hit && (level_ff == cmd.level);
      case (cmd.opcode) inside
         OP_POP, OP_TOP: resp.pick = top_sel;
         OP_FIND:        resp.pick = find_sel;
         default:        resp.pick = 1'b0;
      endcase
      resp.tag   = resp.pick ? tag_ff : '0;
      resp.level = resp.pick ? level_ff : '0;
   end

endmodule

// ----- rtl/tag_level_stack_with_search_unit.sv -----
// Top level of the tag level stack with search unit: the cell row and the result register.
// Depends on tlss_pkg and tlss_cell.
//
// The unit keeps up to DEPTH (tag, indent level) entries in a row of cells,
// bottom entry in cell 0. A command word is taken at a rising edge where
// start is high and busy is low; busy is high only during reset, so the unit
// takes one word every cycle. Every cell compares, shifts or loads in parallel
// in the same edge, and the result word appears on the rsp_ ports, marked by
// rsp_valid, in the cycle right after acceptance. The result is shown for that
// one cycle only and cannot be held off by the receiver. Supported words: push
// (ignored when full), pop, shift out of the bottom, read top, contains (tag and
// level) and find (lowest entry with the tag); opcodes six and seven do nothing.
// Status fields report the store after the word; rsp_entry_count carries the
// low five bits of the count.
module tag_level_stack_with_search_unit import tlss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OpWidth-1:0]       req_opcode,
   input  logic [TagWidth-1:0]      req_tag_value,
   input  logic [LevelWidth-1:0]    req_indent_value,
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic [TagWidth-1:0]      rsp_out_tag,
   output logic [LevelWidth-1:0]    rsp_out_indent,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   output logic [RspCountWidth-1:0] rsp_entry_count
);

   logic                  accept;
   opcode_type            opcode;
   cmd_type               cmd;

   logic                  valid_vec [DEPTH];
   logic [TagWidth-1:0]   tag_vec   [DEPTH];
   logic [LevelWidth-1:0] level_vec [DEPTH];
   logic                  hit_vec   [DEPTH];
   cell_resp_type         resp_vec  [DEPTH];

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  empty;
   logic                  full;

   logic                  any_pick;
   logic                  any_full;
   logic [TagWidth-1:0]   pick_tag;
   logic [LevelWidth-1:0] pick_level;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [TagWidth-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [LevelWidth-1:0]    rsp_level_ff, rsp_level_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_full_ff, rsp_full_in;
   logic [RspCountWidth-1:0] rsp_count_ff, rsp_count_in;

   // hold off new words only while reset is applied
   assign busy   = reset;
   assign accept = start && !busy;
   assign opcode = opcode_type'(req_opcode);

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CountWidth'(DEPTH));

   // broadcast the command word to the row
   always_comb begin
      cmd.push   = accept && (opcode == OP_PUSH);
      cmd.pop    = accept && (opcode == OP_POP);
      cmd.shift  = accept && (opcode == OP_SHIFT);
      cmd.opcode = opcode;
      cmd.tag    = req_tag_value;
      cmd.level  = req_indent_value;
   end

   // Cell row: each cell sees the valid bit of its lower neighbor (for push),
   // the contents of its upper neighbor (for shift and top detect) and the
   // running tag hit from below (for lowest-match find).
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  below_valid;
      logic                  above_valid;
      logic [TagWidth-1:0]   above_tag;
      logic [LevelWidth-1:0] above_level;
      logic                  below_hit;

      if (i == 0) begin : g_bottom
         assign below_valid = 1'b1;
         assign below_hit   = 1'b0;
      end else begin : g_inner_below
         assign below_valid = valid_vec[i-1];
         assign below_hit   = hit_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_top
         assign above_valid = 1'b0;
         assign above_tag   = '0;
         assign above_level = '0;
      end else begin : g_inner_above
         assign above_valid = valid_vec[i+1];
         assign above_tag   = tag_vec[i+1];
         assign above_level = level_vec[i+1];
      end

      tlss_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .valid_below (below_valid),
         .valid_above (above_valid),
         .tag_above   (above_tag),
         .level_above (above_level),
         .hit_below   (below_hit),
         .hit_out     (hit_vec[i]),
         .valid_out   (valid_vec[i]),
         .tag_out     (tag_vec[i]),
         .level_out   (level_vec[i]),
         .resp        (resp_vec[i])
      );
   end

   // Collect what the cells offer; at most one cell picks.
   always_comb begin
      any_pick   = 1'b0;
      any_full   = 1'b0;
      pick_tag   = '0;
      pick_level = '0;
      for (int i = 0; i < DEPTH; i++) begin
         any_pick   = any_pick | resp_vec[i].pick;
         any_full   = any_full | resp_vec[i].full_match;
         pick_tag   = pick_tag | resp_vec[i].tag;
         pick_level = pick_level | resp_vec[i].level;
      end
   end

   // Track the fill level alongside the row.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (opcode) inside
            OP_PUSH: begin
               if (!full) begin
                  count_in = count_ff + CountWidth'(1);
               end
            end
            OP_POP, OP_SHIFT: begin
               if (!empty) begin
                  count_in = count_ff - CountWidth'(1);
               end
            end
            default: count_in = count_ff;
         endcase
      end
   end

   // Form the result word from the state before the edge and the count after it.
   always_comb begin
      rsp_valid_in = accept;
      rsp_found_in = 1'b0;
      rsp_tag_in   = '0;
      rsp_level_in = '0;
      unique case (opcode) inside
         OP_POP, OP_TOP, OP_FIND: begin
            rsp_found_in = any_pick;
            rsp_tag_in   = pick_tag;
            rsp_level_in = pick_level;
         end
         OP_SHIFT: begin
            if (!empty) begin
               rsp_found_in = 1'b1;
               rsp_tag_in   = tag_vec[0];
               rsp_level_in = level_vec[0];
            end
         end
         OP_CONTAINS: begin
            if (any_full) begin
               rsp_found_in = 1'b1;
               rsp_tag_in   = req_tag_value;
               rsp_level_in = req_indent_value;
            end
         end
         default: rsp_found_in = 1'b0;
      endcase
      rsp_empty_in = (count_in == '0);
      rsp_full_in  = (count_in == CountWidth'(DEPTH));
      rsp_count_in = RspCountWidth'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_level_ff <= rsp_level_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_out_indent  = rsp_level_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ----- rtl/tlss_checker.sv -----
// Port-level checks for the tag level stack with search unit, bound to its top level.
// Depends on tlss_pkg.
module tlss_checker import tlss_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [OpWidth-1:0]       req_opcode,
   input logic [TagWidth-1:0]      req_tag_value,
   input logic [LevelWidth-1:0]    req_indent_value,
   input logic                     rsp_valid,
   input logic                     rsp_found,
   input logic [TagWidth-1:0]      rsp_out_tag,
   input logic [LevelWidth-1:0]    rsp_out_indent,
   input logic                     rsp_is_empty,
   input logic                     rsp_is_full,
   input logic [RspCountWidth-1:0] rsp_entry_count
);

   // every accepted word gives exactly one result word, in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted word gave no result");

   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result word without an accepted word");

   // an empty store cannot also be full, and reports a zero count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (!rsp_is_full && rsp_entry_count == '0))
      else $error("empty status inconsistent");

   // no entry returned means zero tag and level
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_out_tag == '0 && rsp_out_indent == '0))
      else $error("data returned without found");

   // a push result never returns an entry
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_PUSH) |=> !rsp_found)
      else $error("push reported found");

endmodule

bind tag_level_stack_with_search_unit tlss_checker u_tlss_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for tag_level_stack_with_search_unit: directed and random command words.
// Depends on tlss_pkg for widths, depth and opcodes; drives the unit through its ports only.
`timescale 1ns / 100ps

module testbench;
   import tlss_pkg::*;

   // Opcodes the unit treats as no operation; they are outside the package enum.
   localparam logic [OpWidth-1:0] OP_SPARE_SIX   = 3'd6;
   localparam logic [OpWidth-1:0] OP_SPARE_SEVEN = 3'd7;

   localparam int RandomWords = 1200;
   localparam int SegmentLen  = 40;
   localparam int PoolSize    = 6;
   localparam int CycleLimit  = 100000;
   localparam int SettleCycles = 8;
   localparam int MaxReports  = 10;

   // Random words come in segments that bias the store toward full, empty or neither.
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_kind_type;

   // One command word waiting to be driven, with the pacing that goes with it.
   typedef struct {
      logic [OpWidth-1:0]    op;
      logic [TagWidth-1:0]   tag;
      logic [LevelWidth-1:0] level;
      int unsigned           idle_pct;
      bit                    drain_first;
   } cmd_word_type;

   // One result word as the unit should report it.
   typedef struct packed {
      logic                     found;
      logic [TagWidth-1:0]      tag;
      logic [LevelWidth-1:0]    level;
      logic                     empty;
      logic                     full;
      logic [RspCountWidth-1:0] count;
   } result_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OpWidth-1:0]       req_opcode = '0;
   logic [TagWidth-1:0]      req_tag_value = '0;
   logic [LevelWidth-1:0]    req_indent_value = '0;
   logic                     rsp_valid;
   logic                     rsp_found;
   logic [TagWidth-1:0]      rsp_out_tag;
   logic [LevelWidth-1:0]    rsp_out_indent;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic [RspCountWidth-1:0] rsp_entry_count;

   tag_level_stack_with_search_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_tag_value    (req_tag_value),
      .req_indent_value (req_indent_value),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_indent   (rsp_out_indent),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the entry store, bottom entry at index 0.
   logic [TagWidth-1:0]   store_tag   [DEPTH];
   logic [LevelWidth-1:0] store_level [DEPTH];
   int                    store_held = 0;

   cmd_word_type    tag_cmd_q[$];     // words not yet driven
   result_word_type result_due_q[$];  // results owed by the unit, oldest first

   int fail_count   = 0;
   int report_count = 0;
   int cycle_count  = 0;
   int num_results  = 0;
   int num_hits     = 0;
   int num_full     = 0;
   int num_empty    = 0;

   // Apply one accepted word to the shadow store and return the result it owes.
   function automatic result_word_type stack_apply(input logic [OpWidth-1:0] op,
                                                   input logic [TagWidth-1:0] tag,
                                                   input logic [LevelWidth-1:0] level);
      result_word_type res;
      int              i;
      res = '0;
      case (op)
         OP_PUSH: begin
            // drop the push silently once the store is full
            if (store_held < DEPTH) begin
               store_tag[store_held]   = tag;
               store_level[store_held] = level;
               store_held++;
            end
         end
         OP_POP: begin
            if (store_held > 0) begin
               store_held--;
               res.found = 1'b1;
               res.tag   = store_tag[store_held];
               res.level = store_level[store_held];
            end
         end
         OP_SHIFT: begin
            if (store_held > 0) begin
               res.found = 1'b1;
               res.tag   = store_tag[0];
               res.level = store_level[0];
               for (i = 0; i + 1 < store_held; i++) begin
                  store_tag[i]   = store_tag[i + 1];
                  store_level[i] = store_level[i + 1];
               end
               store_held--;
            end
         end
         OP_TOP: begin
            if (store_held > 0) begin
               res.found = 1'b1;
               res.tag   = store_tag[store_held - 1];
               res.level = store_level[store_held - 1];
            end
         end
         OP_CONTAINS: begin
            for (i = 0; i < store_held; i++) begin
               if (!res.found && store_tag[i] == tag && store_level[i] == level) begin
                  res.found = 1'b1;
                  res.tag   = tag;
                  res.level = level;
               end
            end
         end
         OP_FIND: begin
            // lowest matching entry wins
            for (i = 0; i < store_held; i++) begin
               if (!res.found && store_tag[i] == tag) begin
                  res.found = 1'b1;
                  res.tag   = store_tag[i];
                  res.level = store_level[i];
               end
            end
         end
         default: begin
         end
      endcase
      res.empty = (store_held == 0);
      res.full  = (store_held == DEPTH);
      res.count = RspCountWidth'(store_held);
      return res;
   endfunction

   // Choose an opcode with weights that depend on the segment kind.
   function automatic logic [OpWidth-1:0] pick_op(input mix_kind_type mode);
      int unsigned r;
      int unsigned w_push, w_pop, w_shift, w_top, w_cont, w_find;
      r = $urandom_range(0, 99);
      case (mode)
         MIX_FILL: begin
            w_push = 70; w_pop = 4; w_shift = 3; w_top = 7; w_cont = 7; w_find = 7;
         end
         MIX_DRAIN: begin
            w_push = 15; w_pop = 30; w_shift = 30; w_top = 8; w_cont = 7; w_find = 7;
         end
         default: begin
            w_push = 35; w_pop = 12; w_shift = 12; w_top = 10; w_cont = 13; w_find = 13;
         end
      endcase
      if (r < w_push) return OP_PUSH;
      r -= w_push;
      if (r < w_pop) return OP_POP;
      r -= w_pop;
      if (r < w_shift) return OP_SHIFT;
      r -= w_shift;
      if (r < w_top) return OP_TOP;
      r -= w_top;
      if (r < w_cont) return OP_CONTAINS;
      r -= w_cont;
      if (r < w_find) return OP_FIND;
      return ($urandom_range(0, 1) != 0) ? OP_SPARE_SIX : OP_SPARE_SEVEN;
   endfunction

   task automatic add_cmd(input logic [OpWidth-1:0] op, input logic [TagWidth-1:0] tag,
                          input logic [LevelWidth-1:0] level, input int unsigned idle_pct,
                          input bit drain_first);
      cmd_word_type w;
      w.op          = op;
      w.tag         = tag;
      w.level       = level;
      w.idle_pct    = idle_pct;
      w.drain_first = drain_first;
      tag_cmd_q.push_back(w);
   endtask

   // Driver: predict each word at the edge that accepts it, then present the
   // next one or idle. Start gets at most one assignment per edge.
   always @(posedge clock) begin : driver
      logic         accepted;
      logic         go;
      logic         settled;
      cmd_word_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            result_due_q.push_back(stack_apply(req_opcode, req_tag_value, req_indent_value));
         end
         if (start && !accepted) begin
            // hold the word until busy drops
         end else if (tag_cmd_q.size() == 0) begin
            start            <= 1'b0;
            req_opcode       <= OpWidth'($urandom);
            req_tag_value    <= TagWidth'($urandom);
            req_indent_value <= LevelWidth'($urandom);
         end else begin
            nxt = tag_cmd_q[0];
            // The last owed result is sampled at this same edge, so treat a
            // single owed word with rsp_valid high as already settled.
            settled = (result_due_q.size() == 0) ||
                      (result_due_q.size() == 1 && rsp_valid === 1'b1);
            if (nxt.drain_first && (accepted || !settled)) begin
               go = 1'b0;
            end else begin
               go = ($urandom_range(0, 99) >= nxt.idle_pct);
            end
            if (go) begin
               void'(tag_cmd_q.pop_front());
               start            <= 1'b1;
               req_opcode       <= nxt.op;
               req_tag_value    <= nxt.tag;
               req_indent_value <= nxt.level;
            end else begin
               // idle with junk on the data ports
               start            <= 1'b0;
               req_opcode       <= OpWidth'($urandom);
               req_tag_value    <= TagWidth'($urandom);
               req_indent_value <= LevelWidth'($urandom);
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest owed word.
   always @(posedge clock) begin : monitor
      result_word_type got;
      result_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_found, rsp_out_tag, rsp_out_indent, rsp_is_empty, rsp_is_full,
                rsp_entry_count};
         num_results++;
         if (result_due_q.size() == 0) begin
            fail_count++;
            if (report_count < MaxReports) begin
               report_count++;
               $display("tb: unexpected result word found=%0b tag=%02h level=%02h",
                        got.found, got.tag, got.level);
            end
         end else begin
            want = result_due_q.pop_front();
            if (got !== want) begin
               fail_count++;
               if (report_count < MaxReports) begin
                  report_count++;
                  $display("tb: mismatch on result %0d at cycle %0d", num_results, cycle_count);
                  $display("    expected found=%0b tag=%02h level=%02h empty=%0b full=%0b count=%0d",
                           want.found, want.tag, want.level, want.empty, want.full, want.count);
                  $display("    actual   found=%0b tag=%02h level=%02h empty=%0b full=%0b count=%0d",
                           got.found, got.tag, got.level, got.empty, got.full, got.count);
               end
            end
            if (want.found) num_hits++;
            if (want.full) num_full++;
            if (want.empty) num_empty++;
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int                    n;
      int                    seg;
      int                    k;
      int unsigned           idle;
      bit                    drain;
      mix_kind_type          mode;
      logic [TagWidth-1:0]   pool [PoolSize];
      logic [TagWidth-1:0]   tag;
      logic [LevelWidth-1:0] level;

      // Directed: every operation on an empty store, the no-op opcodes,
      // extremes of tag and level, a hit and a miss for each search, and
      // draining from both ends back to empty.
      add_cmd(OP_POP,         8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_SHIFT,       8'hFF, 8'hFF, 32, 1'b0);
      add_cmd(OP_TOP,         8'h00, 8'hFF, 32, 1'b0);
      add_cmd(OP_CONTAINS,    8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_FIND,        8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_SPARE_SIX,   8'hFF, 8'hFF, 32, 1'b0);
      add_cmd(OP_SPARE_SEVEN, 8'hA5, 8'h5A, 32, 1'b0);
      add_cmd(OP_PUSH,        8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_PUSH,        8'hFF, 8'hFF, 32, 1'b0);
      add_cmd(OP_PUSH,        8'hAA, 8'h55, 32, 1'b0);
      add_cmd(OP_PUSH,        8'hFF, 8'h01, 32, 1'b0);
      add_cmd(OP_TOP,         8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_CONTAINS,    8'hFF, 8'hFF, 32, 1'b0);
      add_cmd(OP_CONTAINS,    8'hFF, 8'h00, 32, 1'b0);
      add_cmd(OP_FIND,        8'hFF, 8'h00, 32, 1'b0);
      add_cmd(OP_FIND,        8'h12, 8'h00, 32, 1'b0);
      add_cmd(OP_SPARE_SIX,   8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_SHIFT,       8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_POP,         8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_SHIFT,       8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_POP,         8'h00, 8'h00, 32, 1'b0);
      add_cmd(OP_POP,         8'h00, 8'h00, 32, 1'b0);

      // Random: segments cycle fill, drain, blend so the store keeps hitting
      // full and empty. Tags mostly come from a small pool and levels mostly from 0
      // to 3 so the searches hit often; the rest are full random bytes.
      n   = 0;
      seg = 0;
      while (n < RandomWords) begin
         mode = mix_kind_type'(seg % 3);
         for (k = 0; k < PoolSize; k++) pool[k] = TagWidth'($urandom);
         for (k = 0; k < SegmentLen && n < RandomWords; k++) begin
            idle  = (n < RandomWords / 3) ? 32 : (n < 2 * RandomWords / 3) ? 72 : 0;
            drain = (n == RandomWords / 3) || (n == 2 * RandomWords / 3) ||
                    ($urandom_range(0, 99) == 0);
            tag   = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, PoolSize - 1)]
                                                : TagWidth'($urandom);
            level = ($urandom_range(0, 3) != 0) ? LevelWidth'($urandom_range(0, 3))
                                                : LevelWidth'($urandom);
            add_cmd(pick_op(mode), tag, level, idle, drain);
            n++;
         end
         seg++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for the queue to empty and the last word to be taken, then for
      // every owed result, then a settling wait to catch stray strobes.
      @(posedge clock);
      while (tag_cmd_q.size() != 0 || start) @(posedge clock);
      while (result_due_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (result_due_q.size() != 0) begin
         fail_count += result_due_q.size();
         $display("tb: %0d result words never arrived", result_due_q.size());
      end

      $display("tb: checked %0d result words, %0d of them returned an entry or match",
               num_results, num_hits);
      $display("tb: store reported full in %0d words and empty in %0d, %0d mismatches",
               num_full, num_empty, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
